>>> sv/tcipd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcipd_pkg
// Shared types and register indexes for the triplet circle distance check.
// ----------------------------------------------------------------------------
package tcipd_pkg;

  localparam int METRIC_W  = 40;
  localparam int CFG_IDX_W = 8;

  typedef logic [METRIC_W-1:0]  metric_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_METRIC_MIN = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_METRIC_MAX = cfg_idx_t'(1);

endpackage
`default_nettype wire

>>> sv/triplet_circle_ip_distance_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triplet_circle_ip_distance_check
// Fits the circle through three hits and checks |R - d| * R against limits.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_stall  | first_x/y, second_x/y, third_x/y
//  output   | out_valid / out_stall| compatible, degenerate, metric_value
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one triplet per cycle while in_stall is low; the path from transfer to
//  out_valid runs through the front end, the bit-per-cell multiply, root
//  and divide chains and the output register. reset clears the valid bits,
//  sets metric_min to zero and metric_max to all ones.
//  the chain halts only while the output holds a stalled result and the
//  last cell holds another one; bubbles are squeezed out meanwhile.
// ----------------------------------------------------------------------------
module triplet_circle_ip_distance_check #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] first_x,
  input  wire logic signed [COORD_WIDTH-1:0] first_y,
  input  wire logic signed [COORD_WIDTH-1:0] second_x,
  input  wire logic signed [COORD_WIDTH-1:0] second_y,
  input  wire logic signed [COORD_WIDTH-1:0] third_x,
  input  wire logic signed [COORD_WIDTH-1:0] third_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               compatible,
  output logic                               degenerate,
  output tcipd_pkg::metric_t                 metric_value,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire tcipd_pkg::cfg_idx_t           cfg_index,
  input  wire tcipd_pkg::metric_t            cfg_data
);

  import tcipd_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int MAGW = 3 * CW + 4;
  localparam int NMW  = 2 * DW;
  localparam int SRW  = 2 * MAGW + 1;
  localparam int PWID = 2 * SRW;
  localparam int RW   = SRW;
  localparam int DNW  = 2 * NMW + FRAC_BITS;
  localparam int MB   = METRIC_W;
  localparam int XW   = ((SRW > DNW + MB) ? SRW : DNW + MB) + 1;
  localparam int NLANE = 5;
  localparam int LAT  = 8 + MAGW + 1 + SRW + RW + 1 + 1 + MB;

  // control
  logic           en;
  logic [LAT-1:0] vld;
  metric_t        metric_min;
  metric_t        metric_max;

  // front end outputs
  logic [MAGW-1:0] px_mag, py_mag, qx_mag, qy_mag;
  logic [NMW-1:0]  n_mag;
  logic            degen_f;

  // square chain
  logic [MAGW-1:0]   ma_a [0:NLANE-1][0:MAGW];
  logic [MAGW-1:0]   ma_b [0:NLANE-1][0:MAGW];
  logic [2*MAGW-1:0] ma_p [0:NLANE-1][0:MAGW];
  logic              dg_a [0:MAGW];

  // sums
  logic [SRW-1:0] sr_ab, sd_ab;
  logic [DNW-1:0] den_ab;
  logic           dg_ab;

  // product chain
  logic [SRW-1:0]  mb_a [0:SRW];
  logic [SRW-1:0]  mb_b [0:SRW];
  logic [PWID-1:0] mb_p [0:SRW];
  logic [SRW-1:0]  sr_b [0:SRW];
  logic [DNW-1:0]  den_b [0:SRW];
  logic            dg_b [0:SRW];

  // root chain
  logic [PWID-1:0] sq_rad [0:RW];
  logic [RW+1:0]   sq_rem [0:RW];
  logic [RW-1:0]   sq_root [0:RW];
  logic [SRW-1:0]  sr_c [0:RW];
  logic [DNW-1:0]  den_c [0:RW];
  logic            dg_c [0:RW];

  // difference and saturation stages
  logic [SRW-1:0] diff_r;
  logic [DNW-1:0] den_r;
  logic           dg_r;

  // divide chain
  logic [XW-1:0] dv_rem [0:MB];
  logic [XW-1:0] dv_den [0:MB];
  metric_t       dv_q   [0:MB];
  logic          sat_d  [0:MB];
  logic          dg_d   [0:MB];

  metric_t metric_final;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || !out_stall || !vld[LAT-1];
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_min <= '0;
      metric_max <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_METRIC_MIN: metric_min <= cfg_data;
        CFG_METRIC_MAX: metric_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  tcipd_front #(.CW(CW)) u_front (
    .clk    (clk),
    .en     (en),
    .ax     (first_x),
    .ay     (first_y),
    .bx     (second_x),
    .by     (second_y),
    .cx     (third_x),
    .cy     (third_y),
    .px_mag (px_mag),
    .py_mag (py_mag),
    .qx_mag (qx_mag),
    .qy_mag (qy_mag),
    .n_mag  (n_mag),
    .degen  (degen_f)
  );

  // squares of px, py, qx, qy and n
  assign ma_a[0][0] = px_mag;
  assign ma_b[0][0] = px_mag;
  assign ma_a[1][0] = py_mag;
  assign ma_b[1][0] = py_mag;
  assign ma_a[2][0] = qx_mag;
  assign ma_b[2][0] = qx_mag;
  assign ma_a[3][0] = qy_mag;
  assign ma_b[3][0] = qy_mag;
  assign ma_a[4][0] = MAGW'(n_mag);
  assign ma_b[4][0] = MAGW'(n_mag);
  assign dg_a[0]    = degen_f;

  for (genvar j = 0; j < NLANE; j++) begin : g_sq_lane
    assign ma_p[j][0] = '0;
    for (genvar i = 0; i < MAGW; i++) begin : g_sq_cell
      tcipd_mul_cell #(.AW(MAGW), .BW(MAGW), .STEP(i)) u_cell (
        .clk   (clk),
        .en    (en),
        .a_in  (ma_a[j][i]),
        .b_in  (ma_b[j][i]),
        .p_in  (ma_p[j][i]),
        .a_out (ma_a[j][i+1]),
        .b_out (ma_b[j][i+1]),
        .p_out (ma_p[j][i+1])
      );
    end
  end

  for (genvar i = 0; i < MAGW; i++) begin : g_sq_side
    always_ff @(posedge clk) begin
      if (en) begin
        dg_a[i+1] <= dg_a[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_ab  <= SRW'(ma_p[0][MAGW]) + SRW'(ma_p[1][MAGW]);
      sd_ab  <= SRW'(ma_p[2][MAGW]) + SRW'(ma_p[3][MAGW]);
      den_ab <= DNW'(ma_p[4][MAGW][2*NMW-1:0]) << FRAC_BITS;
      dg_ab  <= dg_a[MAGW];
    end
  end

  // product of the two squared distances
  assign mb_a[0]  = sd_ab;
  assign mb_b[0]  = sr_ab;
  assign mb_p[0]  = '0;
  assign sr_b[0]  = sr_ab;
  assign den_b[0] = den_ab;
  assign dg_b[0]  = dg_ab;

  for (genvar i = 0; i < SRW; i++) begin : g_prod
    tcipd_mul_cell #(.AW(SRW), .BW(SRW), .STEP(i)) u_cell (
      .clk   (clk),
      .en    (en),
      .a_in  (mb_a[i]),
      .b_in  (mb_b[i]),
      .p_in  (mb_p[i]),
      .a_out (mb_a[i+1]),
      .b_out (mb_b[i+1]),
      .p_out (mb_p[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sr_b[i+1]  <= sr_b[i];
        den_b[i+1] <= den_b[i];
        dg_b[i+1]  <= dg_b[i];
      end
    end
  end

  // square root of the product
  assign sq_rad[0]  = mb_p[SRW];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sr_c[0]    = sr_b[SRW];
  assign den_c[0]   = den_b[SRW];
  assign dg_c[0]    = dg_b[SRW];

  for (genvar i = 0; i < RW; i++) begin : g_root
    tcipd_sqrt_cell #(.RW(RW)) u_cell (
      .clk      (clk),
      .en       (en),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sr_c[i+1]  <= sr_c[i];
        den_c[i+1] <= den_c[i];
        dg_c[i+1]  <= dg_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= (sr_c[RW] >= sq_root[RW]) ? sr_c[RW] - sq_root[RW]
                                          : sq_root[RW] - sr_c[RW];
      den_r  <= den_c[RW];
      dg_r   <= dg_c[RW];

      dv_rem[0] <= XW'(diff_r);
      dv_den[0] <= XW'(den_r);
      sat_d[0]  <= (XW'(diff_r) >= (XW'(den_r) << MB));
      dg_d[0]   <= dg_r;
    end
  end

  assign dv_q[0] = '0;

  for (genvar i = 0; i < MB; i++) begin : g_div
    tcipd_div_cell #(.XW(XW), .K(MB - 1 - i)) u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (dv_rem[i]),
      .den_in  (dv_den[i]),
      .q_in    (dv_q[i]),
      .rem_out (dv_rem[i+1]),
      .den_out (dv_den[i+1]),
      .q_out   (dv_q[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sat_d[i+1] <= sat_d[i];
        dg_d[i+1]  <= dg_d[i];
      end
    end
  end

  always_comb begin
    if (dg_d[MB]) begin
      metric_final = '0;
    end else if (sat_d[MB]) begin
      metric_final = '1;
    end else begin
      metric_final = dv_q[MB];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      metric_value <= metric_final;
      degenerate   <= dg_d[MB];
      compatible   <= dg_d[MB] ||
                      (metric_final >= metric_min && metric_final <= metric_max);
    end
  end

endmodule
`default_nettype wire

>>> sv/tcipd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcipd_front
// Eight-stage front end: difference vectors, the determinant and the
// unnormalized circle center, delivered as magnitudes.
// ----------------------------------------------------------------------------
module tcipd_front #(
  parameter int CW = 24,
  localparam int DW   = CW + 1,
  localparam int MW   = 3 * CW + 5,
  localparam int MAGW = MW - 1,
  localparam int NMW  = 2 * DW
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] ax,
  input  wire logic signed [CW-1:0] ay,
  input  wire logic signed [CW-1:0] bx,
  input  wire logic signed [CW-1:0] by,
  input  wire logic signed [CW-1:0] cx,
  input  wire logic signed [CW-1:0] cy,
  output logic [MAGW-1:0]           px_mag,
  output logic [MAGW-1:0]           py_mag,
  output logic [MAGW-1:0]           qx_mag,
  output logic [MAGW-1:0]           qy_mag,
  output logic [NMW-1:0]            n_mag,
  output logic                      degen
);

  localparam int SQW = 2 * DW;
  localparam int NW  = 2 * DW + 1;
  localparam int PPW = 2 * DW + 2;

  // stage 1
  logic signed [DW-1:0] ux1, uy1, vx1, vy1;
  logic signed [CW-1:0] ax1, ay1;
  // stage 2
  logic signed [DW-1:0] ux2, uy2, vx2, vy2;
  logic signed [CW-1:0] ax2, ay2;
  logic signed [SQW-1:0] uxux2, uyuy2, vxvx2, vyvy2, uxvy2, uyvx2;
  // stage 3
  logic signed [DW-1:0] ux3, uy3, vx3, vy3;
  logic signed [CW-1:0] ax3, ay3;
  logic [SQW-1:0] uu3, vv3;
  logic signed [NW-1:0] n3;
  // stage 4
  logic signed [PPW-1:0] vyuu_h4, vyuu_l4, uyvv_h4, uyvv_l4;
  logic signed [PPW-1:0] uxvv_h4, uxvv_l4, vxuu_h4, vxuu_l4;
  logic signed [PPW-1:0] axn_h4, axn_l4, ayn_h4, ayn_l4;
  logic signed [NW-1:0] n4;
  // stage 5
  logic signed [MW-1:0] vyuu5, uyvv5, uxvv5, vxuu5, axn5, ayn5;
  logic signed [NW-1:0] n5;
  // stage 6
  logic signed [MW-1:0] px6, py6, axn6, ayn6;
  logic signed [NW-1:0] n6;
  // stage 7
  logic signed [MW-1:0] px7, py7, qx7, qy7;
  logic signed [NW-1:0] n7;

  logic signed [DW:0] n3_hi;

  assign n3_hi = n3[NW-1:DW];

  always_ff @(posedge clk) begin
    if (en) begin
      ux1 <= DW'(bx) - DW'(ax);
      uy1 <= DW'(by) - DW'(ay);
      vx1 <= DW'(cx) - DW'(ax);
      vy1 <= DW'(cy) - DW'(ay);
      ax1 <= ax;
      ay1 <= ay;

      ux2   <= ux1;
      uy2   <= uy1;
      vx2   <= vx1;
      vy2   <= vy1;
      ax2   <= ax1;
      ay2   <= ay1;
      uxux2 <= SQW'(ux1) * SQW'(ux1);
      uyuy2 <= SQW'(uy1) * SQW'(uy1);
      vxvx2 <= SQW'(vx1) * SQW'(vx1);
      vyvy2 <= SQW'(vy1) * SQW'(vy1);
      uxvy2 <= SQW'(ux1) * SQW'(vy1);
      uyvx2 <= SQW'(uy1) * SQW'(vx1);

      ux3 <= ux2;
      uy3 <= uy2;
      vx3 <= vx2;
      vy3 <= vy2;
      ax3 <= ax2;
      ay3 <= ay2;
      uu3 <= SQW'(uxux2 + uyuy2);
      vv3 <= SQW'(vxvx2 + vyvy2);
      n3  <= (NW'(uxvy2) - NW'(uyvx2)) <<< 1;

      // split wide operands into high and low halves
      vyuu_h4 <= PPW'(vy3) * PPW'($signed({1'b0, uu3[SQW-1:DW]}));
      vyuu_l4 <= PPW'(vy3) * PPW'($signed({1'b0, uu3[DW-1:0]}));
      uyvv_h4 <= PPW'(uy3) * PPW'($signed({1'b0, vv3[SQW-1:DW]}));
      uyvv_l4 <= PPW'(uy3) * PPW'($signed({1'b0, vv3[DW-1:0]}));
      uxvv_h4 <= PPW'(ux3) * PPW'($signed({1'b0, vv3[SQW-1:DW]}));
      uxvv_l4 <= PPW'(ux3) * PPW'($signed({1'b0, vv3[DW-1:0]}));
      vxuu_h4 <= PPW'(vx3) * PPW'($signed({1'b0, uu3[SQW-1:DW]}));
      vxuu_l4 <= PPW'(vx3) * PPW'($signed({1'b0, uu3[DW-1:0]}));
      axn_h4  <= PPW'(ax3) * PPW'(n3_hi);
      axn_l4  <= PPW'(ax3) * PPW'($signed({1'b0, n3[DW-1:0]}));
      ayn_h4  <= PPW'(ay3) * PPW'(n3_hi);
      ayn_l4  <= PPW'(ay3) * PPW'($signed({1'b0, n3[DW-1:0]}));
      n4      <= n3;

      vyuu5 <= (MW'(vyuu_h4) <<< DW) + MW'(vyuu_l4);
      uyvv5 <= (MW'(uyvv_h4) <<< DW) + MW'(uyvv_l4);
      uxvv5 <= (MW'(uxvv_h4) <<< DW) + MW'(uxvv_l4);
      vxuu5 <= (MW'(vxuu_h4) <<< DW) + MW'(vxuu_l4);
      axn5  <= (MW'(axn_h4) <<< DW) + MW'(axn_l4);
      ayn5  <= (MW'(ayn_h4) <<< DW) + MW'(ayn_l4);
      n5    <= n4;

      px6  <= vyuu5 - uyvv5;
      py6  <= uxvv5 - vxuu5;
      axn6 <= axn5;
      ayn6 <= ayn5;
      n6   <= n5;

      px7 <= px6;
      py7 <= py6;
      qx7 <= axn6 + px6;
      qy7 <= ayn6 + py6;
      n7  <= n6;

      px_mag <= px7[MW-1] ? MAGW'(-px7) : MAGW'(px7);
      py_mag <= py7[MW-1] ? MAGW'(-py7) : MAGW'(py7);
      qx_mag <= qx7[MW-1] ? MAGW'(-qx7) : MAGW'(qx7);
      qy_mag <= qy7[MW-1] ? MAGW'(-qy7) : MAGW'(qy7);
      n_mag  <= n7[NW-1] ? NMW'(-n7) : NMW'(n7);
      degen  <= (n7 == '0);
    end
  end

endmodule
`default_nettype wire

>>> sv/tcipd_mul_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcipd_mul_cell
// One shift-add step of a multiplier chain: adds the multiplicand, shifted
// by the cell position, when that multiplier bit is set.
// ----------------------------------------------------------------------------
module tcipd_mul_cell #(
  parameter int AW   = 8,
  parameter int BW   = 8,
  parameter int STEP = 0,
  localparam int PW  = AW + BW
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] a_in,
  input  wire logic [BW-1:0] b_in,
  input  wire logic [PW-1:0] p_in,
  output logic [AW-1:0]      a_out,
  output logic [BW-1:0]      b_out,
  output logic [PW-1:0]      p_out
);

  logic [PW-1:0] addend;

  assign addend = b_in[STEP] ? (PW'(a_in) << STEP) : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      a_out <= a_in;
      b_out <= b_in;
      p_out <= p_in + addend;
    end
  end

endmodule
`default_nettype wire

>>> sv/tcipd_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcipd_sqrt_cell
// One digit step of a restoring integer square root: takes two radicand
// bits and decides one root bit.
// ----------------------------------------------------------------------------
module tcipd_sqrt_cell #(
  parameter int RW  = 8,
  localparam int PW = 2 * RW,
  localparam int MW = RW + 2
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [PW-1:0] rad_in,
  input  wire logic [MW-1:0] rem_in,
  input  wire logic [RW-1:0] root_in,
  output logic [PW-1:0]      rad_out,
  output logic [MW-1:0]      rem_out,
  output logic [RW-1:0]      root_out
);

  logic [MW+1:0] r2;
  logic [MW+1:0] trial;
  logic          ge;

  assign r2    = {rem_in, rad_in[PW-1:PW-2]};
  assign trial = (MW+2)'({root_in, 2'b01});
  assign ge    = (r2 >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in << 2;
      rem_out  <= ge ? MW'(r2 - trial) : MW'(r2);
      root_out <= {root_in[RW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> sv/tcipd_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcipd_div_cell
// One quotient bit of a restoring divider: compares the partial remainder
// with the divisor shifted by the bit position and subtracts on success.
// ----------------------------------------------------------------------------
module tcipd_div_cell #(
  parameter int XW = 16,
  parameter int K  = 0
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [XW-1:0]     rem_in,
  input  wire logic [XW-1:0]     den_in,
  input  wire tcipd_pkg::metric_t q_in,
  output logic [XW-1:0]          rem_out,
  output logic [XW-1:0]          den_out,
  output tcipd_pkg::metric_t     q_out
);

  import tcipd_pkg::*;

  logic [XW-1:0] shifted;
  logic          ge;
  metric_t       q_next;

  assign shifted = den_in << K;
  assign ge      = (rem_in >= shifted);

  always_comb begin
    q_next    = q_in;
    q_next[K] = ge;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? rem_in - shifted : rem_in;
      den_out <= den_in;
      q_out   <= q_next;
    end
  end

endmodule
`default_nettype wire
